>>> hw/rtl/wal_frame_scanner_defines.svh
// ---------------------------------------------------------------------------
// wal_frame_scanner_defines.svh
// Assertion macros used by the frame scanner core RTL.
// ---------------------------------------------------------------------------
`ifndef WAL_FRAME_SCANNER_DEFINES_SVH
`define WAL_FRAME_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define WFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wal_frame_scanner: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define WFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wal_frame_scanner: next-cycle check failed");

`endif

>>> hw/rtl/wfs_pkg.sv
// ---------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants of the log frame scanner.
// ---------------------------------------------------------------------------
package wfs_pkg;

  // Field widths
  localparam int FILE_W   = 48;
  localparam int REC_W    = 56;
  localparam int PAD_W    = 3;
  localparam int STATUS_W = 2;
  // Offsets never pass the largest file size plus one length word
  localparam int OFFSET_W = 49;
  // Offset plus record plus pad without wrap
  localparam int SUM_W    = 57;

  localparam int HEADER_BYTES     = 8;
  localparam int SECTOR_BYTES_DEF = 512;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FRAME = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_BYTES    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_SEGMENT = 1'b1;

  // One byte request from the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } wfs_byte_req_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REC_W-1:0]    record_size;
    logic [PAD_W-1:0]    pad_size;
    logic                torn_write;
    logic [FILE_W-1:0]   frame_offset;
  } wfs_result_t;

endpackage

>>> hw/rtl/wfs_in_stage.sv
// ---------------------------------------------------------------------------
// wfs_in_stage
// Input register: holds one byte request until the scan core takes it.
// ---------------------------------------------------------------------------
module wfs_in_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  take,
  output wfs_pkg::wfs_byte_req_t byte_req
);
  import wfs_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;

  // Accept when empty or when the held byte leaves this cycle
  assign in_ready = !valid_r || take;

  // Load a new request, drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        valid_r <= 1'b1;
        data_r  <= in_data_byte;
      end else if (take) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign byte_req.valid     = valid_r;
  assign byte_req.data_byte = data_r;

endmodule

>>> hw/rtl/wfs_core.sv
// ---------------------------------------------------------------------------
// wfs_core
// Frame decode state machine and result register.
// ---------------------------------------------------------------------------
`include "wal_frame_scanner_defines.svh"

module wfs_core #(
  parameter int SECTOR_BYTES = wfs_pkg::SECTOR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wfs_pkg::wfs_byte_req_t        byte_req,
  output logic                          take,
  input  logic [wfs_pkg::FILE_W-1:0]    seg_bytes,
  input  logic                          last_segment,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wfs_pkg::wfs_result_t          out_result
);
  import wfs_pkg::*;

  localparam int SECTOR_W = $clog2(SECTOR_BYTES);

  typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_HALT} phase_t;

  // Control state
  phase_t              phase_r,    phase_nxt;
  logic [2:0]          hdr_cnt_r,  hdr_cnt_nxt;
  logic [SUM_W-1:0]    rem_r,      rem_nxt;
  logic [OFFSET_W-1:0] off_r,      off_nxt;
  logic [SECTOR_W-1:0] off_mod_r,  off_mod_nxt;
  logic [SECTOR_W-1:0] sec_pos_r,  sec_pos_nxt;
  logic                chunk_zero_r, chunk_zero_nxt;
  logic                torn_r,     torn_nxt;
  logic                out_valid_r;

  // Payload state
  logic [REC_W-1:0]    hdr_r,      hdr_nxt;
  logic [REC_W-1:0]    held_rec_r, held_rec_nxt;
  logic [PAD_W-1:0]    held_pad_r, held_pad_nxt;
  logic [OFFSET_W-1:0] held_end_r, held_end_nxt;
  wfs_result_t         out_r,      res;

  // Datapath terms
  logic [7:0]          b;
  logic [PAD_W-1:0]    pad;
  logic [SUM_W-1:0]    sum;
  logic                over;
  logic [SECTOR_W:0]   sec_start_sum;
  logic [SECTOR_W-1:0] sec_start;
  logic                zero_now;
  logic                sec_end;
  logic                last;
  logic                emit;

  assign b = byte_req.data_byte;

  // Length word split and limit check
  assign pad  = b[7] ? b[PAD_W-1:0] : '0;
  assign sum  = {{(SUM_W-OFFSET_W){1'b0}}, off_r} + {{(SUM_W-REC_W){1'b0}}, hdr_r}
              + {{(SUM_W-PAD_W){1'b0}}, pad};
  assign over = sum > {{(SUM_W-FILE_W){1'b0}}, seg_bytes};

  // Sector phase of the first body byte
  assign sec_start_sum = {1'b0, off_mod_r} + (SECTOR_W+1)'(HEADER_BYTES);
  assign sec_start     = (sec_start_sum >= (SECTOR_W+1)'(SECTOR_BYTES))
                       ? SECTOR_W'(sec_start_sum - (SECTOR_W+1)'(SECTOR_BYTES))
                       : sec_start_sum[SECTOR_W-1:0];

  // Body byte terms
  assign zero_now = chunk_zero_r && (b == 8'd0);
  assign sec_end  = sec_pos_r == SECTOR_W'(SECTOR_BYTES - 1);
  assign last     = rem_r == SUM_W'(1);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    rem_nxt        = rem_r;
    off_nxt        = off_r;
    off_mod_nxt    = off_mod_r;
    sec_pos_nxt    = sec_pos_r;
    chunk_zero_nxt = chunk_zero_r;
    torn_nxt       = torn_r;
    hdr_nxt        = hdr_r;
    held_rec_nxt   = held_rec_r;
    held_pad_nxt   = held_pad_r;
    held_end_nxt   = held_end_r;
    emit           = 1'b0;
    res            = '0;
    res.frame_offset = off_r[FILE_W-1:0];
    case (phase_r)
      PH_HEADER: begin
        if (hdr_cnt_r != 3'(HEADER_BYTES - 1)) begin
          // Gather the low seven bytes of the length word
          hdr_nxt     = {b, hdr_r[REC_W-1:8]};
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        end else begin
          hdr_cnt_nxt = 3'd0;
          if (hdr_r == '0 && b == 8'd0) begin
            // End marker: report, keep the offset
            emit       = 1'b1;
            res.status = ST_END;
          end else if (over) begin
            // Frame runs past the file: report and halt
            emit            = 1'b1;
            res.status      = ST_OVER;
            res.record_size = hdr_r;
            res.pad_size    = pad;
            phase_nxt       = PH_HALT;
          end else if (hdr_r == '0 && pad == '0) begin
            // Empty body: the frame ends with its length word
            emit            = 1'b1;
            res.status      = ST_FRAME;
            off_nxt         = off_r + OFFSET_W'(HEADER_BYTES);
            off_mod_nxt     = sec_start;
          end else begin
            // Open the body
            phase_nxt      = PH_BODY;
            rem_nxt        = {{(SUM_W-REC_W){1'b0}}, hdr_r}
                           + {{(SUM_W-PAD_W){1'b0}}, pad};
            held_rec_nxt   = hdr_r;
            held_pad_nxt   = pad;
            held_end_nxt   = sum[OFFSET_W-1:0];
            sec_pos_nxt    = sec_start;
            chunk_zero_nxt = 1'b1;
            torn_nxt       = 1'b0;
          end
        end
      end
      PH_BODY: begin
        // Advance through record and pad bytes
        rem_nxt     = rem_r - SUM_W'(1);
        sec_pos_nxt = sec_end ? '0 : sec_pos_r + SECTOR_W'(1);
        if (sec_end || last) begin
          torn_nxt       = torn_r || zero_now;
          chunk_zero_nxt = 1'b1;
        end else begin
          chunk_zero_nxt = zero_now;
        end
        if (last) begin
          emit            = 1'b1;
          res.status      = ST_FRAME;
          res.record_size = held_rec_r;
          res.pad_size    = held_pad_r;
          res.torn_write  = (torn_r || zero_now) && last_segment;
          off_nxt         = held_end_r + OFFSET_W'(HEADER_BYTES);
          off_mod_nxt     = sec_pos_nxt;
          phase_nxt       = PH_HEADER;
        end
      end
      PH_HALT: begin
        // Drop every byte until reset
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // Take the byte unless its result would find the result register full
  assign take = byte_req.valid && (!emit || !out_valid_r || out_ready);

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= 3'd0;
      rem_r        <= '0;
      off_r        <= '0;
      off_mod_r    <= '0;
      sec_pos_r    <= '0;
      chunk_zero_r <= 1'b1;
      torn_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        phase_r      <= phase_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        rem_r        <= rem_nxt;
        off_r        <= off_nxt;
        off_mod_r    <= off_mod_nxt;
        sec_pos_r    <= sec_pos_nxt;
        chunk_zero_r <= chunk_zero_nxt;
        torn_r       <= torn_nxt;
        hdr_r        <= hdr_nxt;
        held_rec_r   <= held_rec_nxt;
        held_pad_r   <= held_pad_nxt;
        held_end_r   <= held_end_nxt;
      end
      if (take && emit) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Checks
  `WFS_ASSERT_IMPL(a_rise_from_take, clk, rst_n, $rose(out_valid_r), $past(take))
  `WFS_ASSERT_NEXT(a_halt_sticky, clk, rst_n, phase_r == PH_HALT, phase_r == PH_HALT)
  `WFS_ASSERT_IMPL(a_cnt_in_header, clk, rst_n, phase_r != PH_HEADER, hdr_cnt_r == 3'd0)
  `WFS_ASSERT_IMPL(a_body_nonempty, clk, rst_n, phase_r == PH_BODY, rem_r != '0)
  `WFS_ASSERT_IMPL(a_sec_range, clk, rst_n, 1'b1, sec_pos_r <= SECTOR_W'(SECTOR_BYTES - 1))

endmodule

>>> hw/rtl/wal_frame_scanner.sv
// ---------------------------------------------------------------------------
// wal_frame_scanner
// Scans a log segment byte stream into frame results.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_data_byte
//   out_    | output    | out_valid / out_ready | status, sizes, torn flag, offset
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One byte per cycle sustained unless the result side stalls; a byte waits in the
// input register, and its result, if any, shows in the result register in the
// cycle after the core takes it. Reset is synchronous, active low, and needs no
// clearing pass. A byte that gives a result waits in the input register while a
// result is held and out_ready is low; bytes that give no result keep flowing.
// ---------------------------------------------------------------------------
module wal_frame_scanner #(
  parameter int SECTOR_BYTES = wfs_pkg::SECTOR_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wfs_pkg::STATUS_W-1:0]     out_status,
  output logic [wfs_pkg::REC_W-1:0]        out_record_size,
  output logic [wfs_pkg::PAD_W-1:0]        out_pad_size,
  output logic                             out_torn_write,
  output logic [wfs_pkg::FILE_W-1:0]       out_frame_offset,
  input  logic                             cfg_we,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wfs_pkg::FILE_W-1:0]       cfg_wdata
);
  import wfs_pkg::*;

  logic [FILE_W-1:0] seg_bytes_r;
  logic              last_seg_r;
  wfs_byte_req_t     byte_req;
  logic              take;
  wfs_result_t       result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_bytes_r <= '0;
      last_seg_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEG_BYTES:    seg_bytes_r <= cfg_wdata;
        CFG_LAST_SEGMENT: last_seg_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  wfs_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .take         (take),
    .byte_req     (byte_req)
  );

  wfs_core #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_req     (byte_req),
    .take         (take),
    .seg_bytes    (seg_bytes_r),
    .last_segment (last_seg_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (result)
  );

  // Unpack the result request
  assign out_status       = result.status;
  assign out_record_size  = result.record_size;
  assign out_pad_size     = result.pad_size;
  assign out_torn_write   = result.torn_write;
  assign out_frame_offset = result.frame_offset;

endmodule

>>> tb/sv/wal_frame_scanner_test.sv
// ----------------------------------------------------------------------------
// wal_frame_scanner_test
// Self-checking bench for the log frame scanner. Byte requests go in through
// a valid/ready sender with random gaps, and an in-bench scan model predicts
// each frame, end marker and size error. A checker compares every result
// request field by field, in order. Directed frames cover the decode corners
// and the torn-write flag. Random frames run under three idle mixes, then the
// result side stalls for a long stretch, and a size error ends the run.
// ----------------------------------------------------------------------------
module wal_frame_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wfs_pkg::*;

  localparam int SECTOR        = SECTOR_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [FILE_W-1:0] SEG_BYTES_MAX = '1;

  typedef enum logic [1:0] {SCAN_HEADER, SCAN_BODY, SCAN_HALTED} scan_phase_t;
  typedef enum int {
    FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ZERO_TAIL, FILL_ZERO_HEAD, FILL_SPARSE
  } fill_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [REC_W-1:0]     out_record_size;
  logic [PAD_W-1:0]     out_pad_size;
  logic                 out_torn_write;
  logic [FILE_W-1:0]    out_frame_offset;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SEG_BYTES;
  logic [FILE_W-1:0]    cfg_wdata = '0;

  // Scan model state, reset values
  logic [FILE_W-1:0] seg_bytes = '0;
  logic              seg_last = 1'b1;
  scan_phase_t       scan_phase = SCAN_HEADER;
  logic [63:0]       hdr_word = '0;
  int unsigned       hdr_count = 0;
  logic [56:0]       body_left = '0;
  logic [REC_W-1:0]  cur_rec = '0;
  logic [PAD_W-1:0]  cur_pad = '0;
  logic [63:0]       scan_offset = '0;
  int unsigned       sector_pos = 0;
  logic              chunk_zero = 1'b1;
  logic              torn_hit = 1'b0;

  wfs_result_t frames_due[$];
  wfs_result_t due;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int results_predicted = 0;
  int frames_seen = 0;
  int torn_seen_cnt = 0;
  int ends_seen = 0;
  int overs_seen = 0;

  wal_frame_scanner #(
    .SECTOR_BYTES(SECTOR)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_record_size  (out_record_size),
    .out_pad_size     (out_pad_size),
    .out_torn_write   (out_torn_write),
    .out_frame_offset (out_frame_offset),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               frames_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Scan model
  // ---------------------------------------------------------------------------
  task automatic expect_result(input logic [STATUS_W-1:0] st, input logic [REC_W-1:0] rec,
                               input logic [PAD_W-1:0] pad, input logic torn);
    wfs_result_t r;
    r.status       = st;
    r.record_size  = rec;
    r.pad_size     = pad;
    r.torn_write   = torn;
    r.frame_offset = scan_offset[FILE_W-1:0];
    frames_due.push_back(r);
    results_predicted++;
  endtask

  task automatic close_frame();
    expect_result(ST_FRAME, cur_rec, cur_pad, torn_hit && seg_last);
    scan_offset = scan_offset + 64'(HEADER_BYTES) + 64'(cur_rec) + 64'(cur_pad);
    scan_phase  = SCAN_HEADER;
    body_left   = '0;
    sector_pos  = 0;
    chunk_zero  = 1'b1;
    torn_hit    = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic [63:0] word;
    logic [63:0] room;
    logic        over;
    case (scan_phase)
      SCAN_HALTED: begin
      end
      SCAN_HEADER: begin
        hdr_word = hdr_word | (64'(b) << (8 * hdr_count));
        hdr_count++;
        if (hdr_count == HEADER_BYTES) begin
          word = hdr_word;
          hdr_word = '0;
          hdr_count = 0;
          if (word == 64'd0) begin
            expect_result(ST_END, '0, '0, 1'b0);
          end else begin
            cur_rec = word[REC_W-1:0];
            cur_pad = word[63] ? word[58:56] : '0;
            // Header bytes do not count against the segment size
            if (scan_offset > 64'(seg_bytes)) begin
              over = 1'b1;
            end else begin
              room = 64'(seg_bytes) - scan_offset;
              over = (64'(cur_pad) > room) || (64'(cur_rec) > room - 64'(cur_pad));
            end
            if (over) begin
              expect_result(ST_OVER, cur_rec, cur_pad, 1'b0);
              scan_phase = SCAN_HALTED;
            end else begin
              body_left  = 57'(cur_rec) + 57'(cur_pad);
              torn_hit   = 1'b0;
              chunk_zero = 1'b1;
              sector_pos = int'((scan_offset + 64'(HEADER_BYTES)) % 64'(SECTOR));
              if (body_left == '0) begin
                close_frame();
              end else begin
                scan_phase = SCAN_BODY;
              end
            end
          end
        end
      end
      default: begin
        if (b != 8'h00) chunk_zero = 1'b0;
        sector_pos++;
        body_left--;
        // Close a chunk at each sector boundary and at the frame end
        if (sector_pos >= SECTOR || body_left == '0) begin
          if (chunk_zero) torn_hit = 1'b1;
          chunk_zero = 1'b1;
          if (sector_pos >= SECTOR) sector_pos = 0;
        end
        if (body_left == '0) close_frame();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, long hold on demand, in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing due, status %0d offset 0x%0h",
                                out_status, out_frame_offset));
      end else begin
        due = frames_due.pop_front();
        if (out_status !== due.status)
          flag_mismatch($sformatf("status %0d, want %0d at offset 0x%0h",
                                  out_status, due.status, due.frame_offset));
        if (out_record_size !== due.record_size)
          flag_mismatch($sformatf("record_size 0x%0h, want 0x%0h at offset 0x%0h",
                                  out_record_size, due.record_size, due.frame_offset));
        if (out_pad_size !== due.pad_size)
          flag_mismatch($sformatf("pad_size %0d, want %0d at offset 0x%0h",
                                  out_pad_size, due.pad_size, due.frame_offset));
        if (out_torn_write !== due.torn_write)
          flag_mismatch($sformatf("torn_write %0b, want %0b at offset 0x%0h",
                                  out_torn_write, due.torn_write, due.frame_offset));
        if (out_frame_offset !== due.frame_offset)
          flag_mismatch($sformatf("frame_offset 0x%0h, want 0x%0h",
                                  out_frame_offset, due.frame_offset));
        case (due.status)
          ST_FRAME: begin
            frames_seen++;
            if (due.torn_write) torn_seen_cnt++;
          end
          ST_END:  ends_seen++;
          default: overs_seen++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------
  // Offer one byte request; hold it until accepted, then feed the model
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    scan_byte(b);
  endtask

  task automatic send_header(input logic [63:0] word);
    for (int i = 0; i < HEADER_BYTES; i++) push_byte(word[8*i +: 8]);
  endtask

  // top is bits 63..56 of the length word: pad flag, spare bits, pad count
  task automatic send_frame(input int unsigned rec, input logic [7:0] top, input fill_t fill);
    logic [63:0] word;
    int unsigned body_len;
    int unsigned split;
    logic [7:0]  b;
    word = {top, 56'(rec)};
    body_len = (word == 64'd0) ? 0 : rec + (top[7] ? int'(top[2:0]) : 0);
    split = (body_len > 0) ? $urandom_range(0, body_len - 1) : 0;
    send_header(word);
    for (int unsigned i = 0; i < body_len; i++) begin
      case (fill)
        FILL_ZERO:      b = 8'h00;
        FILL_ONES:      b = 8'hFF;
        FILL_ZERO_TAIL: b = (i < split) ? 8'($urandom_range(1, 255)) : 8'h00;
        FILL_ZERO_HEAD: b = (i < split) ? 8'h00 : 8'($urandom_range(1, 255));
        FILL_SPARSE:    b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        default:        b = 8'($urandom);
      endcase
      push_byte(b);
    end
  endtask

  // Mostly short records, some medium, a few spanning sectors
  task automatic random_frame();
    int unsigned pick;
    int unsigned rec;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_frame(0, 8'h00, FILL_RANDOM);
    end else begin
      if (pick < 72)      rec = $urandom_range(0, 24);
      else if (pick < 97) rec = $urandom_range(25, 160);
      else                rec = $urandom_range(400, 700);
      send_frame(rec, 8'($urandom), fill_t'($urandom_range(0, 5)));
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  // Wait for every due result, then let in-flight bytes settle
  task automatic wait_drained();
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_segment(input logic [FILE_W-1:0] fsize, input logic last);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SEG_BYTES;
    cfg_wdata <= fsize;
    @(posedge clk);
    cfg_index <= CFG_LAST_SEGMENT;
    cfg_wdata <= FILE_W'(last);
    @(posedge clk);
    cfg_we <= 1'b0;
    seg_bytes = fsize;
    seg_last  = last;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: empty segment, last segment on
  task automatic test_reset_defaults();
    send_frame(0, 8'h00, FILL_RANDOM);
    send_frame(0, 8'h80, FILL_RANDOM);
    send_frame(0, 8'h00, FILL_RANDOM);
    idle_input();
    wait_drained();
  endtask

  task automatic test_frame_decode();
    set_segment(SEG_BYTES_MAX, 1'b1);
    send_frame(1, 8'h00, FILL_ZERO);
    send_frame(1, 8'h00, FILL_ONES);
    // pad bits without the flag are ignored
    send_frame(3, 8'h7F, FILL_RANDOM);
    send_frame(2, 8'h87, FILL_ONES);
    send_frame(0, 8'h78, FILL_RANDOM);
    send_frame(5, 8'h83, FILL_ZERO);
    send_frame(0, 8'h00, FILL_RANDOM);
    idle_input();
    wait_drained();
  endtask

  task automatic test_torn_disabled();
    set_segment(SEG_BYTES_MAX, 1'b0);
    send_frame(4, 8'h00, FILL_ZERO);
    send_frame(6, 8'h81, FILL_ZERO_TAIL);
    idle_input();
    wait_drained();
  endtask

  // Record plus pad fills the segment exactly; an end marker still passes after
  task automatic test_exact_fit();
    set_segment(scan_offset[FILE_W-1:0] + FILE_W'(16), 1'b1);
    send_frame(13, 8'h83, FILL_SPARSE);
    send_frame(0, 8'h00, FILL_RANDOM);
    idle_input();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [FILE_W-1:0] fsize, input logic last);
    int start_bytes;
    int start_results;
    set_segment(fsize, last);
    tx_idle_pct   = tx_pct;
    rx_idle_pct   = rx_pct;
    start_bytes   = bytes_sent;
    start_results = results_predicted;
    while (bytes_sent - start_bytes < 130 || results_predicted - start_results < 4)
      random_frame();
    idle_input();
    wait_drained();
  endtask

  // Hold off the result side while requests keep coming
  task automatic test_output_stall();
    set_segment(SEG_BYTES_MAX, 1'b1);
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 240;
    repeat (20) send_frame(0, 8'h00, FILL_RANDOM);
    repeat (2) random_frame();
    idle_input();
    wait_drained();
  endtask

  // Size error halts the block; later bytes give nothing
  task automatic test_size_limit();
    tx_idle_pct = 18;
    rx_idle_pct = 46;
    if ($urandom_range(0, 1)) begin
      set_segment('0, 1'b1);
      send_header(64'hFFFF_FFFF_FFFF_FFFF);
    end else begin
      set_segment(scan_offset[FILE_W-1:0] + FILE_W'(16), 1'b0);
      send_header({8'h87, 56'd10});
    end
    repeat (16) push_byte(8'($urandom));
    idle_input();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 18;
    rx_idle_pct = 46;
    test_reset_defaults();
    test_frame_decode();
    test_torn_disabled();
    test_exact_fit();
    test_random_traffic(18, 46, SEG_BYTES_MAX, 1'b1);
    test_random_traffic(46, 18, scan_offset[FILE_W-1:0] + FILE_W'(32'h0100_0000)
                        + FILE_W'($urandom_range(0, 65535)), 1'b0);
    test_random_traffic(0, 0, scan_offset[FILE_W-1:0] + FILE_W'(32'h0010_0000), 1'b1);
    test_output_stall();
    test_size_limit();

    repeat (16) @(posedge clk);
    if (frames_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", frames_due.size()));

    $display("Covered %0d byte requests: %0d frames (%0d torn), %0d end markers,",
             bytes_sent, frames_seen, torn_seen_cnt, ends_seen);
    $display("%0d size errors, under three idle mixes and a long result stall.",
             overs_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
